FILE: sv/arm_pkg.sv
// Shared types, constants and area tables for the address region map.
package arm_pkg;

	localparam int unsigned MaxEntriesDefault = 64;
	localparam int unsigned AddrW = 30;
	localparam int unsigned TagW = 8;
	localparam int unsigned StatusW = 3;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_AUTO = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_FIND = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNKNOWN_AREA = 3'd1;
	localparam logic [2:0] ST_AREA_FULL = 3'd2;
	localparam logic [2:0] ST_OVL_PREV = 3'd3;
	localparam logic [2:0] ST_OVL_NEXT = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] region_class;
		logic [AddrW-1:0] address;
		logic [AddrW-1:0] length;
		logic [TagW-1:0] file_tag;
	} arm_req_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic hit;
		logic [AddrW-1:0] result_address;
		logic [AddrW-1:0] result_length;
		logic [TagW-1:0] result_tag;
	} arm_rsp_t;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [AddrW-1:0] start;
		logic [AddrW-1:0] len;
		logic [TagW-1:0] tag;
	} arm_entry_t;

	function automatic logic [AddrW-1:0] area_begin(input logic [1:0] cls);
		case (cls)
			2'd0: area_begin = 30'h0;
			2'd1: area_begin = 30'h4000000;
			default: area_begin = 30'h20000000;
		endcase
	endfunction

	function automatic logic [AddrW-1:0] area_end(input logic [1:0] cls);
		case (cls)
			2'd0: area_end = 30'h4000000;
			2'd1: area_end = 30'h20000000;
			default: area_end = 30'h3FFFFC00;
		endcase
	endfunction

	// Mask of low bits cleared by the area boundary rounding.
	function automatic logic [AddrW:0] area_mask(input logic [1:0] cls);
		case (cls)
			2'd0: area_mask = 31'h3FF;
			default: area_mask = 31'hFFFFF;
		endcase
	endfunction

endpackage

FILE: sv/address_region_map.sv
// Top level of the address region map: sequencer around the region table.
// A find with a cache hit reads one cached entry; otherwise a scan reads the N stored
// regions in turn; insert and remove add a shift pass that moves each entry through a
// read state and a write state. Each step waits on the registered read of the table memory.
// One request is handled at a time; an output register holds the finished result,
// so the next request is taken while it waits. Reset clears the count, cache and
// control, not the table.
module address_region_map import arm_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input arm_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output arm_rsp_t out_data
);

	localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
	localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_CACHE_RD, S_CACHE_CHK, S_SCAN_RD, S_SCAN_CHK,
		S_PLACE, S_OVL_RD, S_OVL_CHK, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_DONE
	} state_t;

	state_t state_q;
	arm_req_t req_q;
	arm_rsp_t rsp_q;
	arm_rsp_t out_rsp_q;
	logic out_valid_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] hit_idx_q;
	logic hit_valid_q;

	// Scan position; width holds the count itself.
	logic [CntW-1:0] pos_q;
	logic [CntW-1:0] rd_pos_q;
	logic [AddrW-1:0] place_q;
	logic found_q;
	logic [AddrW:0] last_end_q;
	logic [AddrW:0] prev_end_q;
	logic have_prev_q;

	logic mem_we;
	logic [IdxW-1:0] mem_waddr;
	arm_entry_t mem_wdata;
	logic [IdxW-1:0] mem_raddr;
	arm_entry_t mem_rdata;

	arm_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Shared compare unit: the end of the entry just read, and containment of the
	// request address.
	logic [AddrW:0] rd_end;
	logic contains;
	assign rd_end = {1'b0, mem_rdata.start} + {1'b0, mem_rdata.len};
	assign contains = (req_q.address >= mem_rdata.start) && ({1'b0, req_q.address} < rd_end);

	// The rounded end keeps one extra bit so a region ending near the top of the
	// range cannot wrap back into the area.
	logic [AddrW+1:0] rounded;
	assign rounded = ({1'b0, last_end_q} + {1'b0, area_mask(req_q.region_class)})
		& ~{1'b0, area_mask(req_q.region_class)};

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_rsp_q;

	// Memory port control follows the state.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q[IdxW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = pos_q[IdxW-1:0];
		case (state_q)
			S_CACHE_RD: mem_raddr = hit_idx_q;
			S_SHIFT_RD: begin
				// Insert moves entry pos-1 to pos; remove moves pos+1 to pos.
				if (req_q.req_type == REQ_REMOVE) begin
					mem_raddr = IdxW'(pos_q + 1'b1);
				end else begin
					mem_raddr = IdxW'(pos_q - 1'b1);
				end
			end
			S_SHIFT_WR: mem_we = 1'b1;
			S_WRITE: begin
				mem_we = 1'b1;
				mem_waddr = rd_pos_q[IdxW-1:0];
				mem_wdata.start = place_q;
				mem_wdata.len = req_q.length;
				mem_wdata.tag = req_q.file_tag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			out_rsp_q <= '0;
			count_q <= '0;
			hit_valid_q <= 1'b0;
			hit_idx_q <= '0;
			req_q <= '0;
			rsp_q <= '0;
			pos_q <= '0;
			rd_pos_q <= '0;
			place_q <= '0;
			found_q <= 1'b0;
			last_end_q <= '0;
			prev_end_q <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						rsp_q <= '0;
						pos_q <= '0;
						found_q <= 1'b0;
						have_prev_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					place_q <= req_q.address;
					case (req_q.req_type)
						REQ_FIND: begin
							if (hit_valid_q && ({1'b0, hit_idx_q} < count_q)) begin
								state_q <= S_CACHE_RD;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
						REQ_INSERT: begin
							hit_valid_q <= 1'b0;
							if (count_q == CntMax) begin
								rsp_q.status <= ST_TABLE_FULL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_OVL_RD;
							end
						end
						REQ_AUTO: begin
							hit_valid_q <= 1'b0;
							if (req_q.region_class == 2'd3) begin
								rsp_q.status <= ST_UNKNOWN_AREA;
								state_q <= S_DONE;
							end else if (count_q == CntMax) begin
								rsp_q.status <= ST_TABLE_FULL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
						default: begin
							hit_valid_q <= 1'b0;
							state_q <= S_SCAN_RD;
						end
					endcase
				end
				S_CACHE_RD: state_q <= S_CACHE_CHK;
				S_CACHE_CHK: begin
					if (contains) begin
						rsp_q.hit <= 1'b1;
						rsp_q.result_address <= mem_rdata.start;
						rsp_q.result_length <= mem_rdata.len;
						rsp_q.result_tag <= mem_rdata.tag;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (pos_q >= count_q) begin
						if (req_q.req_type == REQ_AUTO) begin
							state_q <= S_PLACE;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					pos_q <= pos_q + 1'b1;
					state_q <= S_SCAN_RD;
					case (req_q.req_type)
						REQ_FIND: begin
							if (contains) begin
								rsp_q.hit <= 1'b1;
								rsp_q.result_address <= mem_rdata.start;
								rsp_q.result_length <= mem_rdata.len;
								rsp_q.result_tag <= mem_rdata.tag;
								hit_idx_q <= pos_q[IdxW-1:0];
								hit_valid_q <= 1'b1;
								state_q <= S_DONE;
							end
						end
						REQ_AUTO: begin
							if (mem_rdata.start >= area_end(req_q.region_class)) begin
								state_q <= S_PLACE;
							end else if (mem_rdata.start >= area_begin(req_q.region_class)) begin
								found_q <= 1'b1;
								last_end_q <= rd_end;
							end
						end
						default: begin
							// Remove: shift later entries down over this one.
							if (mem_rdata.tag == req_q.file_tag) begin
								pos_q <= pos_q;
								state_q <= S_SHIFT_RD;
							end
						end
					endcase
				end
				S_PLACE: begin
					pos_q <= '0;
					if (!found_q) begin
						place_q <= area_begin(req_q.region_class);
						state_q <= S_OVL_RD;
					end else if (rounded >= {2'b0, area_end(req_q.region_class)}) begin
						rsp_q.status <= ST_AREA_FULL;
						state_q <= S_DONE;
					end else begin
						place_q <= rounded[AddrW-1:0];
						state_q <= S_OVL_RD;
					end
				end
				S_OVL_RD: begin
					if (pos_q >= count_q) begin
						if (have_prev_q && prev_end_q > {1'b0, place_q}) begin
							rsp_q.status <= ST_OVL_PREV;
							state_q <= S_DONE;
						end else begin
							rd_pos_q <= pos_q;
							pos_q <= count_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						state_q <= S_OVL_CHK;
					end
				end
				S_OVL_CHK: begin
					if (mem_rdata.start <= place_q) begin
						have_prev_q <= 1'b1;
						prev_end_q <= rd_end;
						pos_q <= pos_q + 1'b1;
						state_q <= S_OVL_RD;
					end else if (have_prev_q && prev_end_q > {1'b0, place_q}) begin
						rsp_q.status <= ST_OVL_PREV;
						state_q <= S_DONE;
					end else if (({1'b0, place_q} + {1'b0, req_q.length}) >
							{1'b0, mem_rdata.start}) begin
						rsp_q.status <= ST_OVL_NEXT;
						state_q <= S_DONE;
					end else begin
						rd_pos_q <= pos_q;
						pos_q <= count_q;
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					if (req_q.req_type == REQ_REMOVE) begin
						if (pos_q + 1'b1 >= count_q) begin
							count_q <= count_q - 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHIFT_WR;
						end
					end else if (pos_q <= rd_pos_q) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					if (req_q.req_type == REQ_REMOVE) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
					state_q <= S_SHIFT_RD;
				end
				S_WRITE: begin
					count_q <= count_q + 1'b1;
					rsp_q.result_address <= place_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// The finished result waits here while the previous one is
					// still held in the output register.
					if (!out_valid_q || out_ready) begin
						out_rsp_q <= rsp_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/arm_table.sv
// Region table memory: one write port, one registered read port.
module arm_table import arm_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
	input logic clk,
	input logic we,
	input logic [$clog2(MAX_ENTRIES)-1:0] waddr,
	input arm_entry_t wdata,
	input logic [$clog2(MAX_ENTRIES)-1:0] raddr,
	output arm_entry_t rdata
);

	arm_entry_t mem_q [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/arm_checker.sv
// Port checker for the address region map, bound to the top level.
module arm_checker import arm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input arm_req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input arm_rsp_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request dropped or changed while stalled");

	a_not_ready_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request finished in zero cycles");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_TABLE_FULL)
		else $error("status code out of range");

	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.status == ST_OK)
		else $error("hit with error status");

endmodule

bind address_region_map arm_checker u_arm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

FILE: dv/region_map_checker.sv
`timescale 1ns / 100ps
// Checker for the address region map: predicts each result and compares it.
module region_map_checker import arm_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input arm_req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input arm_rsp_t out_data,
	output int mismatches,
	output int pending,
	output int checked,
	output logic [5:0] status_seen
);

	localparam logic [31:0] AREA_LO [3] = '{32'h0, 32'h4000000, 32'h20000000};
	localparam logic [31:0] AREA_HI [3] = '{32'h4000000, 32'h20000000, 32'h3FFFFC00};
	localparam logic [31:0] AREA_STEP [3] = '{32'h400, 32'h100000, 32'h100000};

	logic [AddrW-1:0] reg_start [DEPTH];
	logic [AddrW-1:0] reg_len [DEPTH];
	logic [TagW-1:0] reg_tag [DEPTH];
	int region_count;
	int hit_index;
	bit hit_valid;
	arm_rsp_t expected_rsp [$];

	function automatic logic [31:0] region_end(int i);
		return {2'b0, reg_start[i]} + {2'b0, reg_len[i]};
	endfunction

	// Sorted insertion with the overlap checks against both neighbors.
	function automatic logic [2:0] insert_region(logic [AddrW-1:0] addr,
			logic [AddrW-1:0] len, logic [TagW-1:0] tag);
		int pos;
		pos = 0;
		if (region_count >= DEPTH)
			return ST_TABLE_FULL;
		while (pos < region_count && reg_start[pos] <= addr)
			pos++;
		if (pos > 0 && region_end(pos - 1) > {2'b0, addr})
			return ST_OVL_PREV;
		if (pos < region_count && {2'b0, addr} + {2'b0, len} > {2'b0, reg_start[pos]})
			return ST_OVL_NEXT;
		for (int i = region_count; i > pos; i--) begin
			reg_start[i] = reg_start[i - 1];
			reg_len[i] = reg_len[i - 1];
			reg_tag[i] = reg_tag[i - 1];
		end
		reg_start[pos] = addr;
		reg_len[pos] = len;
		reg_tag[pos] = tag;
		region_count++;
		return ST_OK;
	endfunction

	function automatic arm_rsp_t predict_response(arm_req_t r);
		arm_rsp_t rsp;
		logic [31:0] place;
		logic [31:0] mask;
		int last;
		int idx;
		rsp = '0;
		case (r.req_type)
			REQ_INSERT: begin
				hit_valid = 0;
				rsp.status = insert_region(r.address, r.length, r.file_tag);
				if (rsp.status == ST_OK)
					rsp.result_address = r.address;
			end
			REQ_AUTO: begin
				hit_valid = 0;
				if (r.region_class == 2'd3) begin
					rsp.status = ST_UNKNOWN_AREA;
				end else if (region_count >= DEPTH) begin
					rsp.status = ST_TABLE_FULL;
				end else begin
					place = AREA_LO[r.region_class];
					last = -1;
					for (int i = 0; i < region_count; i++) begin
						if ({2'b0, reg_start[i]} >= AREA_HI[r.region_class])
							break;
						if ({2'b0, reg_start[i]} >= AREA_LO[r.region_class])
							last = i;
					end
					if (last >= 0) begin
						mask = AREA_STEP[r.region_class] - 1;
						place = (region_end(last) + mask) & ~mask;
						if (place >= AREA_HI[r.region_class])
							rsp.status = ST_AREA_FULL;
					end
					if (rsp.status == ST_OK) begin
						rsp.status = insert_region(place[AddrW-1:0], r.length, r.file_tag);
						if (rsp.status == ST_OK)
							rsp.result_address = place[AddrW-1:0];
					end
				end
			end
			REQ_REMOVE: begin
				hit_valid = 0;
				for (int i = 0; i < region_count; i++) begin
					if (reg_tag[i] == r.file_tag) begin
						for (int k = i; k + 1 < region_count; k++) begin
							reg_start[k] = reg_start[k + 1];
							reg_len[k] = reg_len[k + 1];
							reg_tag[k] = reg_tag[k + 1];
						end
						region_count--;
						break;
					end
				end
			end
			default: begin
				idx = -1;
				if (hit_valid && hit_index < region_count && r.address >= reg_start[hit_index]
						&& {2'b0, r.address} < region_end(hit_index))
					idx = hit_index;
				if (idx < 0) begin
					for (int i = 0; i < region_count; i++) begin
						if (r.address >= reg_start[i] && {2'b0, r.address} < region_end(i)) begin
							idx = i;
							break;
						end
					end
					if (idx >= 0) begin
						hit_index = idx;
						hit_valid = 1;
					end
				end
				if (idx >= 0) begin
					rsp.hit = 1'b1;
					rsp.result_address = reg_start[idx];
					rsp.result_length = reg_len[idx];
					rsp.result_tag = reg_tag[idx];
				end
			end
		endcase
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		arm_rsp_t want;
		if (!arst_n) begin
			region_count = 0;
			hit_valid = 0;
			hit_index = 0;
			expected_rsp.delete();
			mismatches = 0;
			checked = 0;
			status_seen = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result %p", out_data);
				end else begin
					want = expected_rsp.pop_front();
					checked++;
					if (out_data.status < 6)
						status_seen[out_data.status] = 1'b1;
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result mismatch, expected %p, got %p", want, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				expected_rsp.push_back(predict_response(in_data));
		end
		pending = expected_rsp.size();
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Top of the address region map testbench: stimulus, stalls and the verdict.
module tb;
	import arm_pkg::*;

	localparam int NUM_RANDOM = 1300;
	// Slowest request is a full scan plus a full shift, plus both sides
	// idling; the limit allows several times that over the run.
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	arm_req_t in_data;
	logic out_valid;
	logic out_ready;
	arm_rsp_t out_data;

	int mismatches;
	int pending;
	int checked;
	logic [5:0] status_seen;

	int sent;
	int cycles;
	bit idle_off;
	bit hold_done;
	logic [AddrW-1:0] known_addr [$];

	always #5 clk = ~clk;

	address_region_map uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	region_map_checker #(.DEPTH(MaxEntriesDefault)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.status_seen(status_seen)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("tb NOT OK");
			$finish;
		end
	end

	// Builds one request from its fields.
	function automatic arm_req_t make_req(logic [1:0] kind, logic [1:0] cls,
			logic [AddrW-1:0] addr, logic [AddrW-1:0] len, logic [TagW-1:0] tag);
		arm_req_t r;
		r.req_type = kind;
		r.region_class = cls;
		r.address = addr;
		r.length = len;
		r.file_tag = tag;
		return r;
	endfunction

	// Offers one request and holds it until the block takes it. A random
	// gap of idle cycles may come first, except near the end of the run.
	task automatic send_request(arm_req_t r);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (r.req_type == REQ_INSERT || r.req_type == REQ_AUTO) begin
			known_addr.push_back(r.req_type == REQ_INSERT ? r.address :
				(r.region_class == 2'd0 ? 30'h0 :
				r.region_class == 2'd1 ? 30'h4000000 : 30'h20000000));
			if (known_addr.size() > 64)
				void'(known_addr.pop_front());
		end
	endtask

	function automatic logic [AddrW-1:0] pick_length();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return AddrW'($urandom_range(0, 32'h1000));
		if (roll < 9)
			return AddrW'($urandom_range(0, 32'h100000));
		return AddrW'($urandom());
	endfunction

	function automatic logic [TagW-1:0] pick_tag();
		return ($urandom_range(0, 4) == 0) ? TagW'($urandom_range(0, 255)) :
			TagW'($urandom_range(0, 15));
	endfunction

	// An address near a region that was inserted before, or anywhere at all.
	function automatic logic [AddrW-1:0] pick_address(int near_pct);
		if (known_addr.size() > 0 && $urandom_range(0, 99) < near_pct)
			return AddrW'(known_addr[$urandom_range(0, known_addr.size() - 1)]
				+ $urandom_range(0, 32'h2000));
		return AddrW'($urandom());
	endfunction

	// Growth phases favor inserts so the table fills up and the areas run
	// out; shrink phases favor removes and lookups.
	function automatic arm_req_t random_req(bit grow);
		int roll;
		roll = $urandom_range(0, 99);
		if (grow ? roll < 45 : roll < 10)
			return make_req(REQ_AUTO,
				($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
				AddrW'($urandom()), pick_length(), pick_tag());
		if (grow ? roll < 70 : roll < 20)
			return make_req(REQ_INSERT, 2'($urandom_range(0, 3)), pick_address(50),
				pick_length(), pick_tag());
		if (grow ? roll < 80 : roll < 65)
			return make_req(REQ_REMOVE, 2'($urandom_range(0, 3)),
				AddrW'($urandom()), AddrW'($urandom()), pick_tag());
		return make_req(REQ_FIND, 2'($urandom_range(0, 3)), pick_address(70),
			AddrW'($urandom()), pick_tag());
	endfunction

	// Result side: random stalls, one long hold-off to back the block up
	// into its input, and no stalls at all in the closing stretch.
	initial begin
		out_ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (idle_off) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (!hold_done && sent >= 400) begin
				hold_done = 1;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		cycles = 0;
		sent = 0;
		idle_off = 0;
		hold_done = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table cases, every area, both overlap checks,
		// the unknown area, region ends near the top of the address space,
		// filling an area and the cached lookup.
		send_request(make_req(REQ_FIND, 2'd0, 30'h0, 30'h0, 8'h00));
		send_request(make_req(REQ_REMOVE, 2'd0, 30'h0, 30'h0, 8'hFF));
		send_request(make_req(REQ_AUTO, 2'd3, 30'h0, 30'h10, 8'h01));
		send_request(make_req(REQ_AUTO, 2'd0, 30'h0, 30'h3FFFC01, 8'h02));
		send_request(make_req(REQ_AUTO, 2'd0, 30'h0, 30'h10, 8'h03));
		send_request(make_req(REQ_AUTO, 2'd1, 30'h0, 30'h1, 8'h04));
		send_request(make_req(REQ_AUTO, 2'd1, 30'h0, 30'h0, 8'h05));
		send_request(make_req(REQ_AUTO, 2'd2, 30'h0, 30'h1FFFFB00, 8'h06));
		send_request(make_req(REQ_AUTO, 2'd2, 30'h0, 30'h10, 8'h07));
		send_request(make_req(REQ_INSERT, 2'd3, 30'h3FFFFFFF, 30'h3FFFFFFF, 8'hFF));
		send_request(make_req(REQ_INSERT, 2'd0, 30'h3FFFFFFF, 30'h1, 8'h08));
		send_request(make_req(REQ_INSERT, 2'd0, 30'h3FFFF000, 30'h1000, 8'h09));
		send_request(make_req(REQ_INSERT, 2'd0, 30'h3FFFEFFF, 30'h2, 8'h0A));
		send_request(make_req(REQ_INSERT, 2'd0, 30'h3FFFEF00, 30'h100, 8'h00));
		send_request(make_req(REQ_FIND, 2'd0, 30'h3FFFFFFF, 30'h0, 8'h00));
		send_request(make_req(REQ_FIND, 2'd0, 30'h3FFFFFFF, 30'h0, 8'h00));
		send_request(make_req(REQ_FIND, 2'd0, 30'h3FFFEFFF, 30'h0, 8'h00));
		send_request(make_req(REQ_FIND, 2'd0, 30'h3FFFF000, 30'h0, 8'h00));
		send_request(make_req(REQ_FIND, 2'd0, 30'h3FFFEF00, 30'h0, 8'h00));
		send_request(make_req(REQ_REMOVE, 2'd0, 30'h0, 30'h0, 8'hFF));
		send_request(make_req(REQ_REMOVE, 2'd0, 30'h0, 30'h0, 8'h02));
		send_request(make_req(REQ_AUTO, 2'd0, 30'h0, 30'h3FFFFFFF, 8'h0B));

		// Random part in alternating growth and shrink phases.
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n >= NUM_RANDOM - 200)
				idle_off = 1;
			send_request(random_req(((n / 150) % 2) == 0));
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (300) @(posedge clk);

		$display("Sent %0d requests, %0d results checked, status codes seen %b.",
			sent, checked, status_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("Mismatches: %0d, results still expected: %0d", mismatches, pending);
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/arm_pkg.sv
sv/arm_table.sv
sv/address_region_map.sv
sv/arm_checker.sv
dv/region_map_checker.sv
dv/tb.sv
